/* sv/scc_pkg.sv */
// ----------------------------------------------------------------------------
// scc_pkg: shared types and arithmetic for the spherical coordinate converter
// Fixed-point widths, arctangent table, gain correction and output rounding.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int COORD_WIDTH   = 18;
  localparam int CORDIC_STAGES = 16;
  localparam int GUARD         = 8;
  localparam int AZ_WIDTH      = 16;
  localparam int EL_WIDTH      = 15;
  localparam int ACC_WIDTH     = 32;
  localparam int ANGLE_SHIFT   = 9;
  localparam int DEG180        = 23040;
  localparam int DEG90         = 11520;
  localparam int ANG180        = 180 * 65536;
  localparam int GAIN_SHIFT    = 20;
  localparam int ATAN_LEN      = 24;

  // word field offsets, lowest bit first
  localparam int OFF_Y     = COORD_WIDTH;
  localparam int OFF_Z     = 2 * COORD_WIDTH;
  localparam int OFF_R     = 3 * COORD_WIDTH;
  localparam int OFF_AZ    = 4 * COORD_WIDTH;
  localparam int OFF_EL    = 4 * COORD_WIDTH + AZ_WIDTH;
  localparam int DATA_BITS = 4 * COORD_WIDTH + AZ_WIDTH + EL_WIDTH;
  localparam int TDATA_WIDTH = ((DATA_BITS + 7) / 8) * 8;

  // command codes
  localparam logic CMD_TO_SPH  = 1'b0;
  localparam logic CMD_TO_CART = 1'b1;

  typedef logic signed [ACC_WIDTH-1:0] acc_t;

  // word moving down the pipeline
  typedef struct packed {
    logic valid;
    logic cmd;
    logic flag;
    acc_t x;
    acc_t y;
    acc_t a;
    acc_t aux;
  } scc_word_t;

  typedef struct packed {
    logic neg;
    acc_t ang;
  } rot_start_t;

  // atan(2^-i) in 1/65536 degree
  localparam acc_t ATAN_TAB [ATAN_LEN] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  localparam logic signed [GAIN_SHIFT+1:0] GAIN_C = (GAIN_SHIFT+2)'(636751);

  // multiply by cordic gain inverse, round half up
  function automatic acc_t gain_fix(input acc_t v);
    logic signed [ACC_WIDTH+GAIN_SHIFT+1:0] p;
    p = v * GAIN_C;
    p = (p + (ACC_WIDTH+GAIN_SHIFT+2)'(1 << (GAIN_SHIFT - 1))) >>> GAIN_SHIFT;
    return p[ACC_WIDTH-1:0];
  endfunction

  // drop guard bits with rounding
  function automatic logic signed [ACC_WIDTH:0] round_guard(input acc_t v);
    logic signed [ACC_WIDTH:0] s;
    s = (ACC_WIDTH+1)'(v);
    s = (s + (ACC_WIDTH+1)'(1 << (GUARD - 1))) >>> GUARD;
    return s;
  endfunction

  function automatic logic [COORD_WIDTH-1:0] coord_out(input acc_t v);
    logic signed [ACC_WIDTH:0] s;
    s = round_guard(v);
    if (s > (ACC_WIDTH+1)'((1 << (COORD_WIDTH - 1)) - 1)) begin
      s = (ACC_WIDTH+1)'((1 << (COORD_WIDTH - 1)) - 1);
    end else if (s < -(ACC_WIDTH+1)'(1 << (COORD_WIDTH - 1))) begin
      s = -(ACC_WIDTH+1)'(1 << (COORD_WIDTH - 1));
    end
    return s[COORD_WIDTH-1:0];
  endfunction

  function automatic logic [COORD_WIDTH-1:0] radius_out(input acc_t v);
    logic signed [ACC_WIDTH:0] s;
    s = round_guard(v);
    if (s < 0) begin
      s = '0;
    end else if (s > (ACC_WIDTH+1)'((1 << COORD_WIDTH) - 1)) begin
      s = (ACC_WIDTH+1)'((1 << COORD_WIDTH) - 1);
    end
    return s[COORD_WIDTH-1:0];
  endfunction

  // internal angle to 1/128 degree, clamped to +-lim
  function automatic acc_t angle_out(input acc_t v, input int lim);
    logic signed [ACC_WIDTH:0] s;
    s = (ACC_WIDTH+1)'(v);
    s = (s + (ACC_WIDTH+1)'(1 << (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
    if (s > lim) begin
      s = (ACC_WIDTH+1)'(lim);
    end else if (s < -lim) begin
      s = -(ACC_WIDTH+1)'(lim);
    end
    return s[ACC_WIDTH-1:0];
  endfunction

  // wrap to [-180,180), fold into +-90 with a negated start vector
  function automatic rot_start_t rot_start(input logic signed [AZ_WIDTH-1:0] ang);
    logic signed [AZ_WIDTH+1:0] r;
    rot_start_t o;
    r = (AZ_WIDTH+2)'(ang);
    if (r >= DEG180) begin
      r = (AZ_WIDTH+2)'(r - 2 * DEG180);
    end else if (r < -DEG180) begin
      r = (AZ_WIDTH+2)'(r + 2 * DEG180);
    end
    o.neg = 1'b0;
    if (r > DEG90) begin
      o.neg = 1'b1;
      r = (AZ_WIDTH+2)'(r - DEG180);
    end else if (r < -DEG90) begin
      o.neg = 1'b1;
      r = (AZ_WIDTH+2)'(r + DEG180);
    end
    o.ang = ACC_WIDTH'(r) <<< ANGLE_SHIFT;
    return o;
  endfunction

endpackage

/* sv/spherical_coordinate_convert.sv */
// Pipeline: 37 register stages from the accepted input word to the result word.
// Throughput: one word per cycle; the whole pipeline advances when the
// output register is empty or being taken, and s_tready is that same enable.
// Depth is set by two 16-stage cordic passes, two gain stages and three
// prep/format stages. Synchronous reset clears all valid bits.
// ----------------------------------------------------------------------------
// spherical_coordinate_convert: Cartesian/spherical converter
// Command 0 gives radius, azimuth, elevation; command 1 gives x, y, z.
// ----------------------------------------------------------------------------
module spherical_coordinate_convert import scc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // in_x, in_y, in_z, in_radius, in_azimuth, in_elevation, zero pad
  input  logic [TDATA_WIDTH-1:0] s_tdata,
  // command
  input  logic [0:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // out_x, out_y, out_z, out_radius, out_azimuth, out_elevation, zero pad
  output logic [TDATA_WIDTH-1:0] m_tdata
);

  logic      en;
  scc_word_t prep1_next, prep1;
  scc_word_t pass1, gain1;
  scc_word_t prep2_next, prep2;
  scc_word_t pass2, gain2;
  logic [TDATA_WIDTH-1:0] tdata_next;
  acc_t      az_fmt, el_fmt;

  logic signed [COORD_WIDTH-1:0] in_x, in_y, in_z;
  logic        [COORD_WIDTH-1:0] in_radius;
  logic signed [AZ_WIDTH-1:0]    in_azimuth;
  logic signed [EL_WIDTH-1:0]    in_elevation;
  acc_t       ix, iy, iz;
  rot_start_t rs1, rs2;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign in_x         = s_tdata[COORD_WIDTH-1:0];
  assign in_y         = s_tdata[OFF_Y +: COORD_WIDTH];
  assign in_z         = s_tdata[OFF_Z +: COORD_WIDTH];
  assign in_radius    = s_tdata[OFF_R +: COORD_WIDTH];
  assign in_azimuth   = s_tdata[OFF_AZ +: AZ_WIDTH];
  assign in_elevation = s_tdata[OFF_EL +: EL_WIDTH];

  // first pass setup: fold x into right half plane, or start rotation
  always_comb begin
    ix  = ACC_WIDTH'(in_x) <<< GUARD;
    iy  = ACC_WIDTH'(in_y) <<< GUARD;
    iz  = ACC_WIDTH'(in_z) <<< GUARD;
    rs1 = rot_start(AZ_WIDTH'(in_elevation));
    prep1_next.valid = s_tvalid;
    prep1_next.cmd   = s_tuser[0];
    if (s_tuser[0] == CMD_TO_SPH) begin
      prep1_next.flag = (ix == 0) && (iy == 0);
      prep1_next.aux  = iz;
      if (ix < 0) begin
        prep1_next.x = -ix;
        prep1_next.y = -iy;
        prep1_next.a = (iy >= 0) ? acc_t'(ANG180) : -acc_t'(ANG180);
      end else begin
        prep1_next.x = ix;
        prep1_next.y = iy;
        prep1_next.a = '0;
      end
    end else begin
      prep1_next.flag = 1'b0;
      prep1_next.aux  = ACC_WIDTH'(in_azimuth);
      prep1_next.x    = rs1.neg ? -(ACC_WIDTH'(in_radius) <<< GUARD)
                                :  (ACC_WIDTH'(in_radius) <<< GUARD);
      prep1_next.y    = '0;
      prep1_next.a    = rs1.ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prep1.valid <= 1'b0;
    end else if (en) begin
      prep1 <= prep1_next;
    end
  end

  scc_pass u_pass1 (.clk(clk), .rst(rst), .en(en), .d(prep1), .q(pass1));
  scc_gain u_gain1 (.clk(clk), .rst(rst), .en(en), .d(pass1), .q(gain1));

  // second pass setup: elevation vectoring, or azimuth rotation
  always_comb begin
    rs2 = rot_start(gain1.aux[AZ_WIDTH-1:0]);
    prep2_next.valid = gain1.valid;
    prep2_next.cmd   = gain1.cmd;
    if (gain1.cmd == CMD_TO_SPH) begin
      prep2_next.flag = (gain1.x == 0) && (gain1.aux == 0);
      prep2_next.x    = gain1.x;
      prep2_next.y    = gain1.aux;
      prep2_next.a    = '0;
      prep2_next.aux  = gain1.flag ? '0 : gain1.a;
    end else begin
      prep2_next.flag = 1'b0;
      prep2_next.x    = rs2.neg ? -gain1.x : gain1.x;
      prep2_next.y    = '0;
      prep2_next.a    = rs2.ang;
      prep2_next.aux  = gain1.y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prep2.valid <= 1'b0;
    end else if (en) begin
      prep2 <= prep2_next;
    end
  end

  scc_pass u_pass2 (.clk(clk), .rst(rst), .en(en), .d(prep2), .q(pass2));
  scc_gain u_gain2 (.clk(clk), .rst(rst), .en(en), .d(pass2), .q(gain2));

  // output formatting: round, saturate, pack
  always_comb begin
    az_fmt     = angle_out(gain2.aux, DEG180);
    el_fmt     = angle_out(gain2.a, DEG90);
    tdata_next = '0;
    if (gain2.cmd == CMD_TO_SPH) begin
      tdata_next[OFF_R +: COORD_WIDTH] = radius_out(gain2.x);
      tdata_next[OFF_AZ +: AZ_WIDTH]   = az_fmt[AZ_WIDTH-1:0];
      if (!gain2.flag) begin
        tdata_next[OFF_EL +: EL_WIDTH] = el_fmt[EL_WIDTH-1:0];
      end
    end else begin
      tdata_next[COORD_WIDTH-1:0]      = coord_out(gain2.x);
      tdata_next[OFF_Y +: COORD_WIDTH] = coord_out(gain2.y);
      tdata_next[OFF_Z +: COORD_WIDTH] = coord_out(gain2.aux);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= gain2.valid;
      m_tdata  <= tdata_next;
    end
  end

endmodule

/* sv/scc_pass.sv */
// ----------------------------------------------------------------------------
// scc_pass: one pipelined cordic pass
// One register stage per iteration; vectoring for command 0, rotation for 1.
// ----------------------------------------------------------------------------
module scc_pass import scc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  scc_word_t d,
  output scc_word_t q
);

  scc_word_t stage [CORDIC_STAGES+1];

  assign stage[0] = d;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
    scc_word_t nxt;
    acc_t      dx;
    acc_t      dy;
    logic      up;

    // micro-rotation i
    always_comb begin
      dx  = stage[i].x >>> i;
      dy  = stage[i].y >>> i;
      up  = (stage[i].cmd == CMD_TO_SPH) ? (stage[i].y >= 0) : (stage[i].a < 0);
      nxt = stage[i];
      if (up) begin
        nxt.x = stage[i].x + dy;
        nxt.y = stage[i].y - dx;
        nxt.a = stage[i].a + ATAN_TAB[i];
      end else begin
        nxt.x = stage[i].x - dy;
        nxt.y = stage[i].y + dx;
        nxt.a = stage[i].a - ATAN_TAB[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stage[i+1].valid <= 1'b0;
      end else if (en) begin
        stage[i+1] <= nxt;
      end
    end
  end

  assign q = stage[CORDIC_STAGES];

endmodule

/* sv/scc_gain.sv */
// ----------------------------------------------------------------------------
// scc_gain: cordic gain correction
// Scales x and y by the inverse cordic gain, one register stage.
// ----------------------------------------------------------------------------
module scc_gain import scc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  scc_word_t d,
  output scc_word_t q
);

  scc_word_t nxt;

  // two constant multipliers
  always_comb begin
    nxt   = d;
    nxt.x = gain_fix(d.x);
    nxt.y = gain_fix(d.y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= nxt;
    end
  end

endmodule

/* sv/scc_checker.sv */
// ----------------------------------------------------------------------------
// scc_checker: port-level checks for the converter
// Output stall behavior, ready relation, reset and azimuth range.
// ----------------------------------------------------------------------------
module scc_checker import scc_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [TDATA_WIDTH-1:0] m_tdata
);

  logic signed [AZ_WIDTH-1:0] az;

  assign az = m_tdata[OFF_AZ +: AZ_WIDTH];

  // a stalled result word stays
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result word changed while stalled");

  // pipeline takes a word whenever the output slot frees
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output slot");

  // nothing valid right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // azimuth stays clamped
  a_az_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (az <= DEG180) && (az >= -DEG180))
    else $error("azimuth out of range");

endmodule

bind spherical_coordinate_convert scc_checker u_scc_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata)
);
